@@ sv/cpt_pkg.sv @@
// Package for the contact pair tracker: list sizes, codes and the
// transaction structs of both channels. No dependencies.
package cpt_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int ID_WIDTH   = 16;
  localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int KEY_W      = 2 * ID_WIDTH;

  localparam logic [1:0] OP_COLLISION = 2'd0;
  localparam logic [1:0] OP_TRIGGER   = 2'd1;
  localparam logic [1:0] OP_FLUSH     = 2'd2;

  localparam logic [1:0] KIND_ENTER = 2'd0;
  localparam logic [1:0] KIND_STAY  = 2'd1;
  localparam logic [1:0] KIND_EXIT  = 2'd2;

  localparam logic CH_COLLISION = 1'b0;
  localparam logic CH_TRIGGER   = 1'b1;

  typedef logic [KEY_W-1:0] key_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_MERGE,
    S_FINAL
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] first_id;
    logic [15:0] second_id;
  } in_t;

  typedef struct packed {
    logic        channel;
    logic [15:0] low_id;
    logic [15:0] high_id;
    logic [1:0]  kind;
    logic        overflow_seen;
    logic        last;
  } out_t;

endpackage

@@ sv/contact_pair_enter_stay_exit_tracker_unit.sv @@
// Top level of the contact pair tracker: sorted insertion of records and
// the enter/stay/exit merge on flush. Depends on cpt_pkg.
//
//  channel | ports                       | direction | transaction
//  input   | in_valid, in_ready, in_data | in        | record or flush
//  output  | out_valid, out_ready, out_data | out    | one contact event
//
// A dropped record is settled in S_IDLE; otherwise one
// shared key comparator walks the sorted list to find the insert point.
// A flush walks each channel twice (enters/stays, then exits), one list
// step per cycle through the same comparator while the output is not
// stalled; each pass ends in a closing step, and S_FINAL closes the flush after the four passes.
// Reset clears counts, flags and state; the key lists need no clearing.
// A stalled output holds the walk; one event is held back so that the
// final event of a flush can carry last.
module contact_pair_enter_stay_exit_tracker_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  cpt_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output cpt_pkg::out_t out_data
);
  import cpt_pkg::*;

  state_t state_r, state_nxt;
  key_t cur_r  [2][LIST_DEPTH];
  key_t cur_nxt[2][LIST_DEPTH];
  key_t prev_r  [2][LIST_DEPTH];
  key_t prev_nxt[2][LIST_DEPTH];
  logic [CNT_W-1:0] ucnt_r[2], ucnt_nxt[2];
  logic [CNT_W-1:0] raw_r[2], raw_nxt[2];
  logic [CNT_W-1:0] pcnt_r[2], pcnt_nxt[2];
  logic dropped_r, dropped_nxt;
  logic ch_r, ch_nxt;
  logic pass_r, pass_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, c_r, c_nxt, p_r, p_nxt;
  key_t key_r, key_nxt;
  out_t pend_r, pend_nxt;
  logic pend_v_r, pend_v_nxt;
  out_t out_r, out_nxt;
  logic out_v_r, out_v_nxt;

  logic [ID_WIDTH-1:0] id_a, id_b;
  key_t cmp_a, cmp_b, cur_c, prev_p;
  logic cmp_lt, cmp_eq;
  logic hc, hp, take_c, take_p, emit, out_free;
  logic [CNT_W-1:0] nc, np;
  out_t ev;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_v_r;
  assign out_data  = out_r;
  assign out_free  = !out_v_r || out_ready;

  assign nc     = ucnt_r[ch_r];
  assign np     = pcnt_r[ch_r];
  assign cur_c  = cur_r[ch_r][c_r[IDX_W-1:0]];
  assign prev_p = prev_r[ch_r][p_r[IDX_W-1:0]];
  assign hc     = c_r < nc;
  assign hp     = p_r < np;

  // The one comparator shared by insertion and merge.
  always_comb begin
    if (state_r == S_INSERT) begin
      cmp_a = key_r;
      cmp_b = cur_r[ch_r][i_r[IDX_W-1:0]];
    end else begin
      cmp_a = cur_c;
      cmp_b = prev_p;
    end
    cmp_lt = cmp_a < cmp_b;
    cmp_eq = cmp_a == cmp_b;
  end

  assign take_c = hc && (!hp || cmp_lt);
  assign take_p = !take_c && hp && (!hc || !cmp_eq);
  assign emit   = pass_r ? take_p : !take_p;

  always_comb begin
    key_t k;
    k                = take_p ? prev_p : cur_c;
    ev.channel       = ch_r;
    ev.low_id        = 16'(k[KEY_W-1:ID_WIDTH]);
    ev.high_id       = 16'(k[ID_WIDTH-1:0]);
    ev.kind          = pass_r ? KIND_EXIT : (take_c ? KIND_ENTER : KIND_STAY);
    ev.overflow_seen = dropped_r;
    ev.last          = 1'b0;
  end

  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    prev_nxt    = prev_r;
    ucnt_nxt    = ucnt_r;
    raw_nxt     = raw_r;
    pcnt_nxt    = pcnt_r;
    dropped_nxt = dropped_r;
    ch_nxt      = ch_r;
    pass_nxt    = pass_r;
    i_nxt       = i_r;
    c_nxt       = c_r;
    p_nxt       = p_r;
    key_nxt     = key_r;
    pend_nxt    = pend_r;
    pend_v_nxt  = pend_v_r;
    out_nxt     = out_r;
    out_v_nxt   = out_v_r && !out_ready;
    id_a        = ID_WIDTH'(in_data.first_id);
    id_b        = ID_WIDTH'(in_data.second_id);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_data.operation)
            OP_COLLISION, OP_TRIGGER: begin
              ch_nxt = in_data.operation[0];
              if (raw_r[in_data.operation[0]] >= CNT_W'(LIST_DEPTH)) begin
                dropped_nxt = 1'b1;
              end else begin
                raw_nxt[in_data.operation[0]] = raw_r[in_data.operation[0]] + 1'b1;
                key_nxt   = (id_b < id_a) ? {id_b, id_a} : {id_a, id_b};
                i_nxt     = '0;
                state_nxt = S_INSERT;
              end
            end
            OP_FLUSH: begin
              ch_nxt    = CH_COLLISION;
              pass_nxt  = 1'b0;
              c_nxt     = '0;
              p_nxt     = '0;
              state_nxt = S_MERGE;
            end
            default: ;
          endcase
        end
      end
      S_INSERT: begin
        // The list stays sorted with one entry per key.
        if (i_r == ucnt_r[ch_r] || cmp_lt) begin
          for (int j = 1; j < LIST_DEPTH; j++) begin
            if (CNT_W'(j) > i_r) cur_nxt[ch_r][j] = cur_r[ch_r][j-1];
          end
          cur_nxt[ch_r][i_r[IDX_W-1:0]] = key_r;
          ucnt_nxt[ch_r] = ucnt_r[ch_r] + 1'b1;
          state_nxt      = S_IDLE;
        end else if (cmp_eq) begin
          state_nxt = S_IDLE;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      S_MERGE: begin
        if (!hc && !hp) begin
          c_nxt = '0;
          p_nxt = '0;
          if (!pass_r) begin
            pass_nxt = 1'b1;
          end else if (ch_r == CH_COLLISION) begin
            ch_nxt   = CH_TRIGGER;
            pass_nxt = 1'b0;
          end else begin
            state_nxt = S_FINAL;
          end
        end else if (!(emit && pend_v_r && !out_free)) begin
          if (take_c || !take_p) c_nxt = c_r + 1'b1;
          if (take_p || !take_c) p_nxt = p_r + 1'b1;
          if (emit) begin
            if (pend_v_r) begin
              out_nxt   = pend_r;
              out_v_nxt = 1'b1;
            end
            pend_nxt   = ev;
            pend_v_nxt = 1'b1;
          end
        end
      end
      S_FINAL: begin
        if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            out_nxt      = pend_r;
            out_nxt.last = 1'b1;
            out_v_nxt    = 1'b1;
            pend_v_nxt   = 1'b0;
          end
          prev_nxt    = cur_r;
          pcnt_nxt    = ucnt_r;
          ucnt_nxt[0] = '0;
          ucnt_nxt[1] = '0;
          raw_nxt[0]  = '0;
          raw_nxt[1]  = '0;
          dropped_nxt = 1'b0;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    prev_r <= prev_nxt;
    key_r  <= key_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
    i_r    <= i_nxt;
    c_r    <= c_nxt;
    p_r    <= p_nxt;
    pass_r <= pass_nxt;
    ch_r   <= ch_nxt;
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ucnt_r    <= '{default: '0};
      raw_r     <= '{default: '0};
      pcnt_r    <= '{default: '0};
      dropped_r <= 1'b0;
      pend_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ucnt_r    <= ucnt_nxt;
      raw_r     <= raw_nxt;
      pcnt_r    <= pcnt_nxt;
      dropped_r <= dropped_nxt;
      pend_v_r  <= pend_v_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  // Unique entries never outnumber the records taken.
  a_ucnt_le_raw: assert property (@(posedge clk) disable iff (!rst_n)
    ucnt_r[0] <= raw_r[0] && ucnt_r[1] <= raw_r[1])
    else $error("unique count exceeds record count");

  // Nothing is held back once the block is idle again.
  a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_v_r)
    else $error("held event left behind after flush");

  // The merge walk never runs past either list.
  a_walk_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MERGE) |-> (c_r <= nc && p_r <= np))
    else $error("merge index beyond list");

  // A flush ends with the lists cleared.
  a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINAL && state_nxt == S_IDLE) |=> (raw_r[0] == '0 && raw_r[1] == '0))
    else $error("current lists not cleared after flush");

endmodule

@@ tb/sv/contact_pair_enter_stay_exit_tracker_unit_chk.sv @@
// Checker for the contact pair tracker: watches both channels, predicts the
// contact events of every flush and compares them. Depends on cpt_pkg.
`timescale 1ns / 1ps

module contact_pair_enter_stay_exit_tracker_unit_chk (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  cpt_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  cpt_pkg::out_t out_data,
  output int            fail_count,
  output int            pending_events
);
  import cpt_pkg::*;

  key_t cur_col[$], cur_trg[$], prev_col[$], prev_trg[$];
  logic dropped;
  out_t event_queue[$];

  assign pending_events = event_queue.size();

  function automatic void record_pair(input logic trig, input logic [15:0] a,
                                      input logic [15:0] b);
    logic [15:0] lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (trig) begin
      if (cur_trg.size() >= LIST_DEPTH) dropped = 1'b1;
      else cur_trg = {cur_trg, key_t'({lo, hi})};
    end else begin
      if (cur_col.size() >= LIST_DEPTH) dropped = 1'b1;
      else cur_col = {cur_col, key_t'({lo, hi})};
    end
  endfunction

  function automatic void sort_dedup(ref key_t keys[$]);
    key_t tmp[$];
    keys.sort();
    foreach (keys[i])
      if (i == 0 || keys[i] != keys[i-1]) tmp = {tmp, keys[i]};
    keys = tmp;
  endfunction

  function automatic void emit(input logic ch, input key_t k, input logic [1:0] kd);
    out_t e;
    e.channel = ch;
    e.low_id = k[KEY_W-1:ID_WIDTH];
    e.high_id = k[ID_WIDTH-1:0];
    e.kind = kd;
    e.overflow_seen = dropped;
    e.last = 1'b0;
    event_queue = {event_queue, e};
  endfunction

  function automatic void merge_lists(input logic ch, input key_t cur[$], input key_t prev[$]);
    key_t gone[$];
    int c, p;
    c = 0;
    p = 0;
    while (c < cur.size() || p < prev.size()) begin
      if (c < cur.size() && (p >= prev.size() || cur[c] < prev[p])) begin
        emit(ch, cur[c], KIND_ENTER);
        c++;
      end else if (p < prev.size() && (c >= cur.size() || prev[p] < cur[c])) begin
        gone = {gone, prev[p]};
        p++;
      end else begin
        emit(ch, cur[c], KIND_STAY);
        c++;
        p++;
      end
    end
    foreach (gone[i]) emit(ch, gone[i], KIND_EXIT);
  endfunction

  function automatic void flush_frame();
    int start_size;
    start_size = event_queue.size();
    sort_dedup(cur_col);
    sort_dedup(cur_trg);
    merge_lists(CH_COLLISION, cur_col, prev_col);
    merge_lists(CH_TRIGGER, cur_trg, prev_trg);
    if (event_queue.size() > start_size) event_queue[event_queue.size()-1].last = 1'b1;
    prev_col = cur_col;
    prev_trg = cur_trg;
    cur_col.delete();
    cur_trg.delete();
    dropped = 1'b0;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      cur_col.delete();
      cur_trg.delete();
      prev_col.delete();
      prev_trg.delete();
      event_queue.delete();
      dropped = 1'b0;
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (event_queue.size() == 0) begin
          $display("%0t: unexpected event, expected none, actual %p", $time, out_data);
          fail_count++;
        end else begin
          if (out_data !== event_queue[0]) begin
            $display("%0t: event mismatch, expected %p, actual %p",
                     $time, event_queue[0], out_data);
            fail_count++;
          end
          void'(event_queue.pop_front());
        end
      end
      if (in_valid && in_ready) begin
        case (in_data.operation)
          OP_COLLISION: record_pair(1'b0, in_data.first_id, in_data.second_id);
          OP_TRIGGER:   record_pair(1'b1, in_data.first_id, in_data.second_id);
          OP_FLUSH:     flush_frame();
          default: ;
        endcase
      end
    end
  end

endmodule

@@ tb/sv/contact_pair_enter_stay_exit_tracker_unit_tb.sv @@
// Testbench top for the contact pair tracker: drives records and flushes,
// stalls the result channel and gives the verdict. Depends on cpt_pkg and
// the checker module.
`timescale 1ns / 1ps

module contact_pair_enter_stay_exit_tracker_unit_tb;
  import cpt_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  int fail_count, pending_events;
  logic stimulus_done = 1'b0;
  logic quiet_out = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  contact_pair_enter_stay_exit_tracker_unit dut (.*);

  contact_pair_enter_stay_exit_tracker_unit_chk checker_inst (.*);

  // A small id pool makes repeats, stays and exits likely.
  logic [15:0] id_pool[8];

  // Valid is only dropped before an idle gap, so that back-to-back
  // transactions never assign it twice in one time step.
  task automatic send(input logic [1:0] op, input logic [15:0] a, input logic [15:0] b,
                      input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{operation: op, first_id: a, second_id: b};
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic int draw_gap();
    return quiet_out ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0);
  endfunction

  // Result side: stall for a drawn number of cycles before each event.
  initial begin
    int wait_cycles;
    @(posedge rst_n);
    forever begin
      wait_cycles = draw_gap();
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int n_frame;
    logic [1:0] op;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (id_pool[i]) id_pool[i] = $urandom();

    // Directed: extremes, equal ids, duplicates, reversed order, code 3.
    send(OP_FLUSH, 16'h0, 16'h0, 0);
    send(OP_COLLISION, 16'hFFFF, 16'h0000, 0);
    send(OP_COLLISION, 16'h0000, 16'hFFFF, 0);
    send(OP_COLLISION, 16'h1234, 16'h1234, 0);
    send(OP_TRIGGER, 16'hFFFF, 16'hFFFF, 0);
    send(OP_TRIGGER, 16'h0000, 16'h0000, 0);
    send(2'd3, 16'hAAAA, 16'h5555, 0);
    send(OP_FLUSH, 16'hFFFF, 16'hFFFF, 0);
    send(OP_COLLISION, 16'hFFFF, 16'h0000, 0);
    send(OP_TRIGGER, 16'h5555, 16'hAAAA, 0);
    send(OP_FLUSH, 16'h0, 16'h0, 0);
    // Overflow: seventeen collision records.
    for (int i = 0; i < 17; i++) send(OP_COLLISION, 16'(i * 4099), 16'(~i), 0);
    send(OP_FLUSH, 16'h0, 16'h0, 0);
    send(OP_FLUSH, 16'h0, 16'h0, 0);

    // Random frames of records with a flush at the end of each.
    for (int items = 0; items < 330; ) begin
      quiet_out = ($urandom_range(0, 5) == 0);
      n_frame = $urandom_range(0, 20);
      for (int i = 0; i < n_frame; i++) begin
        op = ($urandom_range(0, 30) == 0) ? 2'd3 : 2'($urandom_range(0, 1));
        if ($urandom_range(0, 4) == 0)
          send(op, 16'($urandom()), 16'($urandom()), draw_gap());
        else
          send(op, id_pool[$urandom_range(0, 7)], id_pool[$urandom_range(0, 7)],
               draw_gap());
        items++;
      end
      send(OP_FLUSH, 16'($urandom()), 16'($urandom()), draw_gap());
      items++;
      if ($urandom_range(0, 9) == 0) id_pool[$urandom_range(0, 7)] = $urandom();
    end
    in_valid <= 1'b0;
    stimulus_done <= 1'b1;
  end

  initial begin
    wait (stimulus_done);
    while (pending_events != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("contact_pair_enter_stay_exit_tracker_unit_tb passed");
    else
      $display("contact_pair_enter_stay_exit_tracker_unit_tb failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("contact_pair_enter_stay_exit_tracker_unit_tb failed");
    $finish;
  end

endmodule

@@ sim.f @@
sv/cpt_pkg.sv
sv/contact_pair_enter_stay_exit_tracker_unit.sv
tb/sv/contact_pair_enter_stay_exit_tracker_unit_chk.sv
tb/sv/contact_pair_enter_stay_exit_tracker_unit_tb.sv
